FILE: rtl/lfrl_pkg.sv
// Shared types and constants for the level file range lookup block.
// Used by the search engine, the result stage and the top level; no dependencies.
`default_nettype none

package lfrl_pkg;

  // Fixed widths of the external payload fields.
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned LEVEL_W     = 3;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned KEY_PORT_W  = 64;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned HIT_LEVEL_W = 3;
  localparam int unsigned HIT_SLOT_W  = 6;

  // Internal hit record widths, large enough for the widest configuration.
  localparam int unsigned REC_LEVEL_W = 4;
  localparam int unsigned REC_SLOT_W  = 10;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE  = 2'd0,
    REQ_COUNT  = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_INIT,
    ENG_PROBE,
    ENG_CMP,
    ENG_ADV
  } eng_state_t;

  typedef enum logic {
    OUT_COLLECT,
    OUT_EMIT
  } out_state_t;

  // Handoff from the search engine to the result stage.
  typedef struct packed {
    logic                   hit;
    logic                   done;
    logic [REC_LEVEL_W-1:0] lvl;
    logic [REC_SLOT_W-1:0]  slot;
  } hit_rec_t;

endpackage

`default_nettype wire

FILE: rtl/lfrl_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module lfrl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 448,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/lfrl_engine.sv
// Request decoder and search sequencer: range writes, level counts, and the
// per-level scan / binary search over the key range RAMs. Uses lfrl_pkg.
`default_nettype none

module lfrl_engine #(
  parameter int unsigned LEVELS          = 7,
  parameter int unsigned FILES_PER_LEVEL = 64,
  parameter int unsigned KEY_BITS        = 64,
  localparam int unsigned DEPTH = LEVELS * FILES_PER_LEVEL,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [lfrl_pkg::REQ_W-1:0]         req_type,
  input  wire logic [lfrl_pkg::LEVEL_W-1:0]       level,
  input  wire logic [lfrl_pkg::SLOT_W-1:0]        slot,
  input  wire logic [lfrl_pkg::KEY_PORT_W-1:0]    range_low,
  input  wire logic [lfrl_pkg::KEY_PORT_W-1:0]    range_high,
  input  wire logic [lfrl_pkg::COUNT_W-1:0]       file_count,
  input  wire logic [lfrl_pkg::KEY_PORT_W-1:0]    search_key,
  input  wire logic                               out_busy,
  output lfrl_pkg::hit_rec_t                      rec,
  output logic                                    ram_we,
  output logic [AW-1:0]                           ram_waddr,
  output logic [KEY_BITS-1:0]                     ram_wlow,
  output logic [KEY_BITS-1:0]                     ram_whigh,
  output logic [AW-1:0]                           ram_raddr,
  input  wire logic [KEY_BITS-1:0]                ram_rlow,
  input  wire logic [KEY_BITS-1:0]                ram_rhigh
);

  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned SW = $clog2(FILES_PER_LEVEL);
  localparam int unsigned CW = $clog2(FILES_PER_LEVEL + 1);
  localparam logic [AW-1:0] FPL_A     = AW'(FILES_PER_LEVEL);
  localparam logic [LW-1:0] LAST_LVL  = LW'(LEVELS - 1);
  localparam logic [CW-1:0] CNT_MAX   = CW'(FILES_PER_LEVEL);

  lfrl_pkg::eng_state_t state, state_next;
  logic [LW-1:0]       lvl, lvl_next;
  logic [CW-1:0]       span_lo, span_lo_next;
  logic [CW-1:0]       span_hi, span_hi_next;
  logic [SW-1:0]       mid, mid_next;
  logic [KEY_BITS-1:0] key, key_next;
  logic [CW-1:0]       counts [LEVELS];

  logic          level_ok;
  logic          slot_ok;
  logic          cnt_we;
  logic [CW-1:0] cnt_sat;
  logic [CW:0]   span_sum;
  logic [SW-1:0] probe_mid;
  logic          above;
  logic          below;

  assign level_ok = 32'(level) < LEVELS;
  assign slot_ok  = 32'(slot) < FILES_PER_LEVEL;
  assign cnt_sat  = (32'(file_count) > FILES_PER_LEVEL) ? CNT_MAX : CW'(file_count);

  // Level 0 is scanned in slot order; higher levels probe the midpoint.
  assign span_sum  = {1'b0, span_lo} + {1'b0, span_hi};
  assign probe_mid = (lvl == '0) ? SW'(span_lo) : SW'(span_sum >> 1);

  assign above = key > ram_rhigh;
  assign below = key < ram_rlow;

  assign ram_waddr = AW'(LW'(level)) * FPL_A + AW'(SW'(slot));
  assign ram_wlow  = range_low[KEY_BITS-1:0];
  assign ram_whigh = range_high[KEY_BITS-1:0];
  assign ram_raddr = AW'(lvl) * FPL_A + AW'(probe_mid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfrl_pkg::ENG_IDLE;
      for (int i = 0; i < LEVELS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cnt_we) begin
        counts[LW'(level)] <= cnt_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl     <= lvl_next;
    span_lo <= span_lo_next;
    span_hi <= span_hi_next;
    mid     <= mid_next;
    key     <= key_next;
  end

  always_comb begin
    state_next   = state;
    lvl_next     = lvl;
    span_lo_next = span_lo;
    span_hi_next = span_hi;
    mid_next     = mid;
    key_next     = key;
    in_ready     = 1'b0;
    ram_we       = 1'b0;
    cnt_we       = 1'b0;
    rec          = '0;
    case (state)
      lfrl_pkg::ENG_IDLE: begin
        in_ready = !out_busy;
        if (in_valid && !out_busy) begin
          case (req_type)
            lfrl_pkg::REQ_WRITE: begin
              ram_we = level_ok && slot_ok;
            end
            lfrl_pkg::REQ_COUNT: begin
              cnt_we = level_ok;
            end
            lfrl_pkg::REQ_LOOKUP: begin
              key_next   = search_key[KEY_BITS-1:0];
              lvl_next   = '0;
              state_next = lfrl_pkg::ENG_INIT;
            end
            default: begin
            end
          endcase
        end
      end
      lfrl_pkg::ENG_INIT: begin
        span_lo_next = '0;
        span_hi_next = counts[lvl];
        state_next   = lfrl_pkg::ENG_PROBE;
      end
      lfrl_pkg::ENG_PROBE: begin
        if (span_lo < span_hi) begin
          mid_next   = probe_mid;
          state_next = lfrl_pkg::ENG_CMP;
        end else begin
          state_next = lfrl_pkg::ENG_ADV;
        end
      end
      lfrl_pkg::ENG_CMP: begin
        if (!above && !below) begin
          rec.hit    = 1'b1;
          rec.lvl    = lfrl_pkg::REC_LEVEL_W'(lvl);
          rec.slot   = lfrl_pkg::REC_SLOT_W'(mid);
          state_next = lfrl_pkg::ENG_ADV;
        end else begin
          if (above || lvl == '0) begin
            span_lo_next = CW'(mid) + CW'(1);
          end else begin
            span_hi_next = CW'(mid);
          end
          state_next = lfrl_pkg::ENG_PROBE;
        end
      end
      lfrl_pkg::ENG_ADV: begin
        if (lvl == LAST_LVL) begin
          rec.done   = 1'b1;
          state_next = lfrl_pkg::ENG_IDLE;
        end else begin
          lvl_next   = lvl + LW'(1);
          state_next = lfrl_pkg::ENG_INIT;
        end
      end
      default: begin
        state_next = lfrl_pkg::ENG_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/lfrl_out.sv
// Result stage: collects per-level hits of one lookup, then walks the levels
// and drives the output register with the last beat marked. Uses lfrl_pkg.
`default_nettype none

module lfrl_out #(
  parameter int unsigned LEVELS = 7
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  lfrl_pkg::hit_rec_t                       rec,
  output logic                                     busy,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     found,
  output logic [lfrl_pkg::HIT_LEVEL_W-1:0]         hit_level,
  output logic [lfrl_pkg::HIT_SLOT_W-1:0]          hit_slot,
  output logic                                     last
);

  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  lfrl_pkg::out_state_t state, state_next;
  logic [LEVELS-1:0]                  hit_vec, hit_vec_next;
  logic [lfrl_pkg::HIT_SLOT_W-1:0]    hit_slots [LEVELS];
  logic [LW-1:0]                      walk, walk_next;
  logic                               out_valid_next;
  logic                               found_next;
  logic [lfrl_pkg::HIT_LEVEL_W-1:0]   hit_level_next;
  logic [lfrl_pkg::HIT_SLOT_W-1:0]    hit_slot_next;
  logic                               last_next;
  logic                               more_above;
  logic                               slot_free;

  assign busy      = state == lfrl_pkg::OUT_EMIT;
  assign slot_free = !out_valid || out_ready;

  // Any hit in a level above the one being walked means this beat is not last.
  always_comb begin
    more_above = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      if (LW'(i) > walk && hit_vec[i]) begin
        more_above = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lfrl_pkg::OUT_COLLECT;
      hit_vec   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      hit_vec   <= hit_vec_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    walk      <= walk_next;
    found     <= found_next;
    hit_level <= hit_level_next;
    hit_slot  <= hit_slot_next;
    last      <= last_next;
    if (rec.hit) begin
      hit_slots[LW'(rec.lvl)] <= lfrl_pkg::HIT_SLOT_W'(rec.slot);
    end
  end

  always_comb begin
    state_next     = state;
    hit_vec_next   = hit_vec;
    walk_next      = walk;
    out_valid_next = out_valid && !out_ready;
    found_next     = found;
    hit_level_next = hit_level;
    hit_slot_next  = hit_slot;
    last_next      = last;
    case (state)
      lfrl_pkg::OUT_COLLECT: begin
        if (rec.hit) begin
          hit_vec_next[LW'(rec.lvl)] = 1'b1;
        end
        if (rec.done) begin
          walk_next  = '0;
          state_next = lfrl_pkg::OUT_EMIT;
        end
      end
      lfrl_pkg::OUT_EMIT: begin
        if (slot_free) begin
          if (hit_vec == '0) begin
            out_valid_next = 1'b1;
            found_next     = 1'b0;
            hit_level_next = '0;
            hit_slot_next  = '0;
            last_next      = 1'b1;
            state_next     = lfrl_pkg::OUT_COLLECT;
          end else if (hit_vec[walk]) begin
            out_valid_next = 1'b1;
            found_next     = 1'b1;
            hit_level_next = lfrl_pkg::HIT_LEVEL_W'(walk);
            hit_slot_next  = hit_slots[walk];
            last_next      = !more_above;
            if (!more_above) begin
              hit_vec_next = '0;
              state_next   = lfrl_pkg::OUT_COLLECT;
            end else begin
              walk_next = walk + LW'(1);
            end
          end else begin
            walk_next = walk + LW'(1);
          end
        end
      end
      default: begin
        state_next = lfrl_pkg::OUT_COLLECT;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/lsm_level_file_range_lookup.sv
// Level file range lookup, top level. Write and count beats are taken while idle.
// A lookup spends per level a setup state, a probe and a compare state per probe
// (the RAM read port is registered), an advance state, and one more probe state
// when the level misses; level 0 probes up to its count, higher levels up to
// log2(count)+1. The result stage then walks the levels, held by output stalls,
// and requests wait. Reset clears the level counts and control state, not key RAMs.
`default_nettype none

module lsm_level_file_range_lookup #(
  parameter int unsigned LEVELS          = 7,
  parameter int unsigned FILES_PER_LEVEL = 64,
  parameter int unsigned KEY_BITS        = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [lfrl_pkg::REQ_W-1:0]          req_type,
  input  wire logic [lfrl_pkg::LEVEL_W-1:0]        level,
  input  wire logic [lfrl_pkg::SLOT_W-1:0]         slot,
  input  wire logic [lfrl_pkg::KEY_PORT_W-1:0]     range_low,
  input  wire logic [lfrl_pkg::KEY_PORT_W-1:0]     range_high,
  input  wire logic [lfrl_pkg::COUNT_W-1:0]        file_count,
  input  wire logic [lfrl_pkg::KEY_PORT_W-1:0]     search_key,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     found,
  output logic [lfrl_pkg::HIT_LEVEL_W-1:0]         hit_level,
  output logic [lfrl_pkg::HIT_SLOT_W-1:0]          hit_slot,
  output logic                                     last
);

  localparam int unsigned DEPTH = LEVELS * FILES_PER_LEVEL;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // The engine drives both key RAMs with a shared address; entries of a level
  // are stored contiguously at level * FILES_PER_LEVEL + slot.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [KEY_BITS-1:0] ram_wlow;
  logic [KEY_BITS-1:0] ram_whigh;
  logic [KEY_BITS-1:0] ram_rlow;
  logic [KEY_BITS-1:0] ram_rhigh;

  // Hits flow to the result stage, which holds off new beats while it emits.
  lfrl_pkg::hit_rec_t rec;
  logic               out_busy;

  lfrl_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (DEPTH)
  ) u_low_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wlow),
    .raddr (ram_raddr),
    .rdata (ram_rlow)
  );

  lfrl_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (DEPTH)
  ) u_high_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_whigh),
    .raddr (ram_raddr),
    .rdata (ram_rhigh)
  );

  lfrl_engine #(
    .LEVELS          (LEVELS),
    .FILES_PER_LEVEL (FILES_PER_LEVEL),
    .KEY_BITS        (KEY_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .level      (level),
    .slot       (slot),
    .range_low  (range_low),
    .range_high (range_high),
    .file_count (file_count),
    .search_key (search_key),
    .out_busy   (out_busy),
    .rec        (rec),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wlow   (ram_wlow),
    .ram_whigh  (ram_whigh),
    .ram_raddr  (ram_raddr),
    .ram_rlow   (ram_rlow),
    .ram_rhigh  (ram_rhigh)
  );

  // The output register lets a new beat be accepted while the final result of
  // the previous lookup still waits on out_ready.
  lfrl_out #(
    .LEVELS (LEVELS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .rec       (rec),
    .busy      (out_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .hit_level (hit_level),
    .hit_slot  (hit_slot),
    .last      (last)
  );

endmodule

`default_nettype wire

FILE: sim/lsm_level_file_range_lookup_tb.sv
// Self-checking testbench for the level file range lookup block.
// A directed table and constrained-by-hand random traffic are checked against a local predictor.
// Depends only on lfrl_pkg and the lsm_level_file_range_lookup RTL.
`default_nettype none

module lsm_level_file_range_lookup_tb;

  localparam int NUM_LEVELS = 7;
  localparam int SLOTS      = 64;

  // Request code that the block must drop without any effect.
  localparam logic [1:0]  REQ_UNUSED = 2'd3;
  localparam logic [63:0] KEY_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;

  // Counted beats per idling phase, stall limit and trailing quiet time.
  localparam int PHASE_BEATS    = 50;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int MAX_PRINTS     = 50;

  typedef struct packed {
    logic       found;
    logic [2:0] lvl;
    logic [5:0] slot;
    logic       last;
  } hit_t;

  // One row of the directed table. Rows with a typed-in hit skip the predictor.
  typedef struct {
    logic [1:0]  req;
    logic [2:0]  lvl;
    logic [5:0]  slot;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [6:0]  cnt;
    logic [63:0] key;
    bit          typed;
    hit_t        want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic [2:0]  level;
  logic [5:0]  slot;
  logic [63:0] range_low;
  logic [63:0] range_high;
  logic [6:0]  file_count;
  logic [63:0] search_key;
  logic        out_valid;
  logic        out_ready;
  logic        found;
  logic [2:0]  hit_level;
  logic [5:0]  hit_slot;
  logic        last;

  // Local copy of the file tables. The written flags keep every lookup away
  // from entries that were never loaded, since their contents are undefined.
  logic [63:0] lo_key [NUM_LEVELS*SLOTS];
  logic [63:0] hi_key [NUM_LEVELS*SLOTS];
  bit          written [NUM_LEVELS*SLOTS];
  logic [6:0]  lvl_count [NUM_LEVELS];

  // Result beats still owed by the block, oldest first.
  hit_t     hits_due[$];
  hit_t     head_hit;
  dir_row_t directed[$];

  int mismatch_count;
  int beats_counted;
  int send_idle_pct;
  int recv_idle_pct;
  int idle_cycles;

  lsm_level_file_range_lookup #(
    .LEVELS(NUM_LEVELS),
    .FILES_PER_LEVEL(SLOTS),
    .KEY_BITS(64)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .level(level),
    .slot(slot),
    .range_low(range_low),
    .range_high(range_high),
    .file_count(file_count),
    .search_key(search_key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found(found),
    .hit_level(hit_level),
    .hit_slot(hit_slot),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic hit_t hit_of(input logic f, input logic [2:0] l, input logic [5:0] s,
                                  input logic lst);
    hit_t h;
    h.found = f;
    h.lvl   = l;
    h.slot  = s;
    h.last  = lst;
    return h;
  endfunction

  function automatic dir_row_t step_row(input logic [1:0] rt, input logic [2:0] lvl,
                                        input logic [5:0] slt, input logic [63:0] lo,
                                        input logic [63:0] hi, input logic [6:0] cnt,
                                        input logic [63:0] key, input bit typed = 1'b0,
                                        input hit_t want = '0);
    dir_row_t r;
    r.req   = rt;
    r.lvl   = lvl;
    r.slot  = slt;
    r.lo    = lo;
    r.hi    = hi;
    r.cnt   = cnt;
    r.key   = key;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // Append one row at the end of the directed table.
  task automatic add_row(input dir_row_t r);
    directed.insert(directed.size(), r);
  endtask

  // Walk the levels the way the block does: a first-match scan of level 0,
  // then a binary search of each higher level. At most one hit per level;
  // with no hit at all a single not-found beat is owed.
  task automatic locate_key(input logic [63:0] key);
    hit_t        hits[$];
    int unsigned b;
    int unsigned e;
    int unsigned m;
    int unsigned idx;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (l == 0) begin
        for (int s = 0; s < lvl_count[0]; s++) begin
          if (key <= hi_key[s] && key >= lo_key[s]) begin
            hits.insert(hits.size(), hit_of(1'b1, 3'd0, 6'(s), 1'b0));
            break;
          end
        end
      end else begin
        b = 0;
        e = lvl_count[l];
        while (b < e) begin
          m   = (b + e) >> 1;
          idx = l * SLOTS + m;
          if (key > hi_key[idx]) begin
            b = m + 1;
          end else if (key < lo_key[idx]) begin
            e = m;
          end else begin
            hits.insert(hits.size(), hit_of(1'b1, 3'(l), 6'(m), 1'b0));
            break;
          end
        end
      end
    end
    if (hits.size() == 0) begin
      hits.insert(0, hit_of(1'b0, 3'd0, 6'd0, 1'b0));
    end
    hits[hits.size()-1].last = 1'b1;
    foreach (hits[i]) hits_due.insert(hits_due.size(), hits[i]);
  endtask

  // Apply one accepted request beat to the local tables.
  task automatic apply_request(input logic [1:0] rt, input logic [2:0] lvl,
                               input logic [5:0] slt, input logic [63:0] lo,
                               input logic [63:0] hi, input logic [6:0] cnt,
                               input logic [63:0] key);
    int idx;
    idx = lvl * SLOTS + slt;
    case (rt)
      lfrl_pkg::REQ_WRITE: begin
        if (lvl < NUM_LEVELS) begin
          lo_key[idx]  = lo;
          hi_key[idx]  = hi;
          written[idx] = 1'b1;
        end
      end
      lfrl_pkg::REQ_COUNT: begin
        // Counts above the table depth saturate.
        if (lvl < NUM_LEVELS) lvl_count[lvl] = (cnt > SLOTS) ? 7'(SLOTS) : cnt;
      end
      lfrl_pkg::REQ_LOOKUP: locate_key(key);
      default: ;
    endcase
  endtask

  function automatic int written_prefix(input int l);
    int p;
    p = 0;
    while (p < SLOTS && written[l*SLOTS+p]) p++;
    return p;
  endfunction

  // Pick a key near a live range of level l: its edges, one past each edge,
  // a point inside, or anything at all.
  function automatic logic [63:0] probe_key(input int l);
    int          s;
    int          idx;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] span;
    if (lvl_count[l] == 0) return rand64();
    s    = $urandom_range(lvl_count[l] - 1);
    idx  = l * SLOTS + s;
    lo   = lo_key[idx];
    hi   = hi_key[idx];
    span = hi - lo;
    case ($urandom_range(5))
      0: return lo;
      1: return hi;
      2: return lo - 64'd1;
      3: return hi + 64'd1;
      4: begin
        if (hi >= lo && span != KEY_MAX) return lo + rand64() % (span + 64'd1);
        return lo;
      end
      default: return rand64();
    endcase
  endfunction

  // Send one request beat. Valid is held from the falling edge until the
  // rising edge that accepts the beat; the predictor is updated at that edge,
  // before any result for it can appear.
  task automatic issue(input logic [1:0] rt, input logic [2:0] lvl, input logic [5:0] slt,
                       input logic [63:0] lo, input logic [63:0] hi, input logic [6:0] cnt,
                       input logic [63:0] key, input bit typed = 1'b0,
                       input hit_t want = '0);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    req_type   = rt;
    level      = lvl;
    slot       = slt;
    range_low  = lo;
    range_high = hi;
    file_count = cnt;
    search_key = key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) hits_due.insert(hits_due.size(), want);
    else apply_request(rt, lvl, slt, lo, hi, cnt, key);
    beats_counted++;
  endtask

  // Load slots 0..n-1 of a level with sorted ranges, set its count, then
  // probe it. Gaps and widths may be zero, and the outer edges may sit at
  // the ends of the key space.
  task automatic build_level(input logic [2:0] lvl, input int n, input logic [6:0] cnt);
    logic [63:0] unit;
    logic [63:0] cur;
    logic [63:0] lo;
    logic [63:0] hi;
    unit = KEY_MAX / 64'(2 * n + 2);
    cur  = 64'd0;
    for (int s = 0; s < n; s++) begin
      lo = cur + (($urandom_range(3) == 0) ? 64'd0 : rand64() % unit);
      hi = lo + (($urandom_range(3) == 0) ? 64'd0 : rand64() % unit);
      if (s == n - 1 && $urandom_range(3) == 0) hi = KEY_MAX;
      issue(lfrl_pkg::REQ_WRITE, lvl, 6'(s), lo, hi, 7'($urandom_range(127)), rand64());
      cur = hi + 64'd1;
    end
    issue(lfrl_pkg::REQ_COUNT, lvl, 6'($urandom_range(63)), rand64(), rand64(), cnt,
          rand64());
    repeat ($urandom_range(6, 2)) begin
      issue(lfrl_pkg::REQ_LOOKUP, 3'($urandom_range(7)), 6'($urandom_range(63)),
            rand64(), rand64(), 7'($urandom_range(127)), probe_key(lvl));
    end
  endtask

  // One random step. Most traffic is well-formed level loads and probing
  // lookups; the rest is stray writes, counts, dropped requests and raw keys.
  task automatic random_step();
    int         pick;
    int         n;
    int         p;
    logic [2:0] lvl;
    logic [6:0] cnt;
    pick = $urandom_range(99);
    lvl  = 3'($urandom_range(7));
    if (pick < 15) begin
      n = ($urandom_range(9) == 0) ? SLOTS : $urandom_range(8, 1);
      if (n == SLOTS) cnt = 7'($urandom_range(127, SLOTS));
      else cnt = ($urandom_range(4) == 0) ? 7'($urandom_range(n)) : 7'(n);
      build_level(3'($urandom_range(NUM_LEVELS - 1)), n, cnt);
    end else if (pick < 23) begin
      case ($urandom_range(2))
        0: issue(lfrl_pkg::REQ_LOOKUP, lvl, 6'($urandom_range(63)), rand64(), rand64(),
                 7'($urandom_range(127)), 64'd0);
        1: issue(lfrl_pkg::REQ_LOOKUP, lvl, 6'($urandom_range(63)), rand64(), rand64(),
                 7'($urandom_range(127)), KEY_MAX);
        default: issue(lfrl_pkg::REQ_LOOKUP, lvl, 6'($urandom_range(63)), rand64(), rand64(),
                       7'($urandom_range(127)), rand64());
      endcase
    end else if (pick < 35) begin
      issue(lfrl_pkg::REQ_WRITE, lvl, 6'($urandom_range(63)), rand64(), rand64(),
            7'($urandom_range(127)), rand64());
    end else if (pick < 47) begin
      // Only counts that cover loaded slots; level 7 takes anything.
      p = (lvl < NUM_LEVELS) ? written_prefix(lvl) : SLOTS;
      cnt = (p == SLOTS) ? 7'($urandom_range(127)) : 7'($urandom_range(p));
      issue(lfrl_pkg::REQ_COUNT, lvl, 6'($urandom_range(63)), rand64(), rand64(), cnt,
            rand64());
    end else if (pick < 53) begin
      issue(REQ_UNUSED, lvl, 6'($urandom_range(63)), rand64(), rand64(),
            7'($urandom_range(127)), rand64());
    end else begin
      issue(lfrl_pkg::REQ_LOOKUP, lvl, 6'($urandom_range(63)), rand64(), rand64(),
            7'($urandom_range(127)), probe_key($urandom_range(NUM_LEVELS - 1)));
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // The receiver stalls at random; the chance is set per phase.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted result beat is compared with the oldest owed hit.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (hits_due.size() == 0) begin
        report_mismatch($sformatf("result with none pending: found %0d level %0d slot %0d last %0d",
                                  found, hit_level, hit_slot, last));
      end else begin
        head_hit = hits_due.pop_front();
        if (found !== head_hit.found)
          report_mismatch($sformatf("found %0d, want %0d", found, head_hit.found));
        if (hit_level !== head_hit.lvl)
          report_mismatch($sformatf("hit_level %0d, want %0d", hit_level, head_hit.lvl));
        if (hit_slot !== head_hit.slot)
          report_mismatch($sformatf("hit_slot %0d, want %0d", hit_slot, head_hit.slot));
        if (last !== head_hit.last)
          report_mismatch($sformatf("last %0d, want %0d", last, head_hit.last));
      end
    end
  end

  // A long stretch with no beat on either side means the block is stuck.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat accepted in %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    req_type       = 2'd0;
    level          = 3'd0;
    slot           = 6'd0;
    range_low      = 64'd0;
    range_high     = 64'd0;
    file_count     = 7'd0;
    search_key     = 64'd0;
    out_ready      = 1'b0;
    mismatch_count = 0;
    beats_counted  = 0;
    idle_cycles    = 0;
    send_idle_pct  = 6;
    recv_idle_pct  = 63;
    foreach (written[i]) begin
      written[i] = 1'b0;
      lo_key[i]  = 64'd0;
      hi_key[i]  = 64'd0;
    end
    foreach (lvl_count[i]) lvl_count[i] = 7'd0;

    // Directed table. Hits that follow directly from the rows above them are
    // typed in; the rest go through the predictor.
    // Empty tables after reset: both ends of the key space miss.
    add_row(step_row(lfrl_pkg::REQ_LOOKUP, 3'd0, 6'd0, 64'd0, 64'd0, 7'd0, 64'd0,
                     1'b1, hit_of(1'b0, 3'd0, 6'd0, 1'b1)));
    add_row(step_row(lfrl_pkg::REQ_LOOKUP, 3'd0, 6'd0, 64'd0, 64'd0, 7'd0, KEY_MAX,
                     1'b1, hit_of(1'b0, 3'd0, 6'd0, 1'b1)));
    // Two overlapping level-0 files; the first one that holds the key wins.
    add_row(step_row(lfrl_pkg::REQ_WRITE, 3'd0, 6'd0, 64'd0, 64'h10, 7'd0, 64'd0));
    add_row(step_row(lfrl_pkg::REQ_WRITE, 3'd0, 6'd1, 64'd5, KEY_MAX, 7'd0, 64'd0));
    add_row(step_row(lfrl_pkg::REQ_COUNT, 3'd0, 6'd0, 64'd0, 64'd0, 7'd2, 64'd0));
    add_row(step_row(lfrl_pkg::REQ_LOOKUP, 3'd0, 6'd0, 64'd0, 64'd0, 7'd0, 64'd0,
                     1'b1, hit_of(1'b1, 3'd0, 6'd0, 1'b1)));
    add_row(step_row(lfrl_pkg::REQ_LOOKUP, 3'd0, 6'd0, 64'd0, 64'd0, 7'd0, KEY_MAX,
                     1'b1, hit_of(1'b1, 3'd0, 6'd1, 1'b1)));
    add_row(step_row(lfrl_pkg::REQ_LOOKUP, 3'd0, 6'd0, 64'd0, 64'd0, 7'd0, 64'd7,
                     1'b1, hit_of(1'b1, 3'd0, 6'd0, 1'b1)));
    // Top level holds a one-key file at the maximum key: two hits, last on the second.
    add_row(step_row(lfrl_pkg::REQ_WRITE, 3'd6, 6'd0, KEY_MAX, KEY_MAX, 7'd0, 64'd0));
    add_row(step_row(lfrl_pkg::REQ_COUNT, 3'd6, 6'd0, 64'd0, 64'd0, 7'd1, 64'd0));
    add_row(step_row(lfrl_pkg::REQ_LOOKUP, 3'd0, 6'd0, 64'd0, 64'd0, 7'd0, KEY_MAX));
    // Sorted level 1 with a gap between its second and third files.
    add_row(step_row(lfrl_pkg::REQ_WRITE, 3'd1, 6'd0, 64'h100, 64'h1FF, 7'd0, 64'd0));
    add_row(step_row(lfrl_pkg::REQ_WRITE, 3'd1, 6'd1, 64'h200, 64'h2FF, 7'd0, 64'd0));
    add_row(step_row(lfrl_pkg::REQ_WRITE, 3'd1, 6'd2, 64'h400, KEY_MAX, 7'd0, 64'd0));
    add_row(step_row(lfrl_pkg::REQ_COUNT, 3'd1, 6'd0, 64'd0, 64'd0, 7'd3, 64'd0));
    add_row(step_row(lfrl_pkg::REQ_LOOKUP, 3'd0, 6'd0, 64'd0, 64'd0, 7'd0, 64'h250));
    add_row(step_row(lfrl_pkg::REQ_LOOKUP, 3'd0, 6'd0, 64'd0, 64'd0, 7'd0, 64'h300));
    // Level 7 does not exist, and request code 3 is not defined: all dropped.
    add_row(step_row(lfrl_pkg::REQ_COUNT, 3'd7, 6'd0, 64'd0, 64'd0, 7'd127, 64'd0));
    add_row(step_row(lfrl_pkg::REQ_WRITE, 3'd7, 6'd63, KEY_MAX, 64'd0, 7'd0, 64'd0));
    add_row(step_row(REQ_UNUSED, 3'd7, 6'd63, KEY_MAX, KEY_MAX, 7'd127, KEY_MAX));
    // Emptying level 0 leaves a small key with nowhere to land.
    add_row(step_row(lfrl_pkg::REQ_COUNT, 3'd0, 6'd0, 64'd0, 64'd0, 7'd0, 64'd0));
    add_row(step_row(lfrl_pkg::REQ_LOOKUP, 3'd0, 6'd0, 64'd0, 64'd0, 7'd0, 64'd3,
                     1'b1, hit_of(1'b0, 3'd0, 6'd0, 1'b1)));
    // Top slot written but outside the count, so it must stay invisible.
    add_row(step_row(lfrl_pkg::REQ_WRITE, 3'd2, 6'd63, 64'd0, KEY_MAX, 7'd0, 64'd0));
    add_row(step_row(lfrl_pkg::REQ_LOOKUP, 3'd0, 6'd0, 64'd0, 64'd0, 7'd0, 64'h1FF));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) begin
      issue(directed[i].req, directed[i].lvl, directed[i].slot, directed[i].lo,
            directed[i].hi, directed[i].cnt, directed[i].key, directed[i].typed,
            directed[i].want);
    end

    // A full level with an oversized count exercises saturation.
    build_level(3'd3, SLOTS, 7'd127);

    // Sender mostly busy and receiver mostly stalled, then the reverse,
    // then both at full rate.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 63 : 0;
      recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 6 : 0;
      beats_counted = 0;
      while (beats_counted < PHASE_BEATS) random_step();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: lsm_level_file_range_lookup.f
rtl/lfrl_pkg.sv
rtl/lfrl_ram.sv
rtl/lfrl_engine.sv
rtl/lfrl_out.sv
rtl/lsm_level_file_range_lookup.sv
sim/lsm_level_file_range_lookup_tb.sv
